// ----- rtl/mqb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqb_pkg
// Shared widths, codes, queue entry and result types and the exp2 root table
// for the multiview quality blend core.
// ----------------------------------------------------------------------------
package mqb_pkg;

    localparam int COLOR_BITS  = 16;
    localparam int QFRAC_BITS  = 16;
    localparam int QUAL_W      = 32;
    localparam int WSUM_W      = 40;
    localparam int CSUM_W      = 56;
    localparam int PROD_W      = QUAL_W + COLOR_BITS;
    localparam int EXP_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int TDATA_W     = ((3 * COLOR_BITS + QUAL_W + 7) / 8) * 8;
    localparam int ROOT_W      = 31;
    localparam int ROOT_N      = 16;

    localparam logic signed [EXP_W-1:0] EXP_UNITY = 16'sd256;
    localparam logic [EXP_W-1:0]        EXP_RESET = 16'd256;
    localparam logic [QUAL_W-1:0]       QONE      = QUAL_W'(64'd1 << QFRAC_BITS);
    localparam logic [QUAL_W-1:0]       QMAX      = '1;

    typedef enum logic [1:0] {
        CFG_EXPONENT    = 2'd0,
        CFG_EMPTY_RED   = 2'd1,
        CFG_EMPTY_GREEN = 2'd2,
        CFG_EMPTY_BLUE  = 2'd3
    } cfg_index_t;

    typedef enum logic {
        LE_WEIGHT  = 1'b0,
        LE_QUALITY = 1'b1
    } le_mode_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [QUAL_W-1:0]     quality;
        logic                  prolonged;
        logic                  last;
    } view_t;

    // one finished pixel: the sums already chosen (primary or secondary)
    typedef struct packed {
        logic signed [EXP_W-1:0]     expo;
        logic [WSUM_W-1:0]           wsum;
        logic [2:0][CSUM_W-1:0]      csum;
        logic                        use_sec;
        logic [QUAL_W-1:0]           best_q;
        logic [2:0][COLOR_BITS-1:0]  best_c;
        logic                        best_p;
    } mqb_entry_t;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [QUAL_W-1:0]     quality;
        logic                  pmask;
        logic                  inpaint;
    } result_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] xv;
        res = '0;
        xv  = x;
        for (int i = 31; i >= 0; i--) begin
            bitv = 64'd1 << (2 * i);
            if (xv >= res + bitv) begin
                xv  = xv - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // c_n = 2^(2^-n) in Q1.30, n = 1..16, by repeated truncated square roots
    function automatic logic [ROOT_N*ROOT_W-1:0] root_table();
        logic [63:0]              c;
        logic [ROOT_N*ROOT_W-1:0] t;
        c = 64'd2 << 30;
        t = '0;
        for (int n = 0; n < ROOT_N; n++) begin
            c = isqrt64(c << 30);
            t[n*ROOT_W +: ROOT_W] = c[ROOT_W-1:0];
        end
        return t;
    endfunction

endpackage

// ----- rtl/mqb_div.sv -----
// ----------------------------------------------------------------------------
// mqb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mqb_div
    import mqb_pkg::*;
#(
    parameter int N = CSUM_W,
    parameter int D = WSUM_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quot,
    output logic [D-1:0] rem
);

    localparam int CNT_W = $clog2(N + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N-1:0]     q_reg;
    logic [D-1:0]     r_reg;
    logic [D-1:0]     dv_reg;
    logic [D:0]       trial;
    logic [D:0]       diff;
    logic             ge;

    assign trial = {r_reg, q_reg[N-1]};
    assign ge    = trial >= {1'b0, dv_reg};
    assign diff  = trial - {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg  <= dividend;
            r_reg  <= '0;
            dv_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[N-2:0], ge};
            r_reg <= ge ? diff[D-1:0] : trial[D-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- rtl/mqb_logexp.sv -----
// ----------------------------------------------------------------------------
// mqb_logexp
// Fixed-point power unit: exp2(e*log2(x)/256) or exp2(log2(x)*256/e),
// log2 by normalize and 16 squarings, exp2 by 16 root multiplies.
// ----------------------------------------------------------------------------
module mqb_logexp
    import mqb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  le_mode_t                mode,
    input  logic [WSUM_W-1:0]       x,
    input  logic signed [EXP_W-1:0] expo,
    output logic                    done,
    output logic [QUAL_W-1:0]       result
);

    localparam logic [ROOT_N*ROOT_W-1:0] ROOTS = root_table();
    localparam int P_W    = $clog2(WSUM_W);
    localparam int SH_OFS = QFRAC_BITS - 30;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_NORM  = 7'b0000010,
        S_LOG   = 7'b0000100,
        S_SCALE = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_EXP   = 7'b0100000,
        S_FIN   = 7'b1000000
    } le_state_t;

    le_state_t               state_reg;
    logic [WSUM_W-1:0]       xn_reg;
    logic signed [EXP_W-1:0] e_reg;
    logic [P_W-1:0]          p_reg;
    logic [ROOT_W-1:0]       m_reg;
    logic [15:0]             f_reg;
    logic [3:0]              cnt_reg;
    logic [31:0]             pw_reg;
    logic [ROOT_W-1:0]       r_reg;
    logic                    neg_reg;
    logic                    done_reg;
    logic [QUAL_W-1:0]       result_reg;

    logic [61:0]        sq;
    logic [31:0]        sq_top;
    logic signed [7:0]  pint;
    logic signed [23:0] lval;
    logic signed [39:0] wprod;
    logic signed [39:0] wsh;
    logic signed [31:0] adiv;
    logic [31:0]        amag;
    logic               div_start;
    logic               div_done;
    logic [31:0]        quot;
    logic [EXP_W-1:0]   rem;
    logic [31:0]        pq;
    logic [61:0]        emul;
    logic [15:0]        fr;
    logic [15:0]        ip;
    logic [16:0]        sh;
    logic [16:0]        namt;
    logic               sat;
    logic [32:0]        vw;
    logic [QUAL_W-1:0]  v;

    assign sq     = m_reg * m_reg;
    assign sq_top = sq[61:30];
    assign pint   = $signed({{(8-P_W){1'b0}}, p_reg}) - 8'sd16;
    assign lval   = {pint, f_reg};
    assign wprod  = e_reg * lval;
    assign wsh    = wprod >>> 8;
    assign adiv   = {lval, 8'b0};
    assign amag   = adiv[31] ? 32'(-adiv) : adiv;
    assign div_start = (state_reg == S_SCALE) && (mode == LE_QUALITY);

    mqb_div #(
        .N (32),
        .D (EXP_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (amag),
        .divisor  (e_reg),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    // floor for a negative dividend
    assign pq = !neg_reg ? quot : ((rem != '0) ? ~quot : ~quot + 32'd1);

    assign fr   = pw_reg[15:0];
    assign ip   = pw_reg[31:16];
    assign emul = r_reg * ROOTS[int'(cnt_reg)*ROOT_W +: ROOT_W];
    assign sh   = {ip[15], ip} + 17'(SH_OFS);
    assign namt = -sh;
    assign sat  = $signed(ip) >= $signed(16'(QUAL_W - QFRAC_BITS));
    assign vw   = 33'(r_reg) << sh[0];

    always_comb
    begin
        if (sat)
            v = QMAX;
        else if (!sh[16])
            v = vw[32] ? QMAX : vw[31:0];
        else if (namt >= 17'd31)
            v = '0;
        else
            v = 32'(r_reg >> namt[4:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (xn_reg[WSUM_W-1])
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= (mode == LE_WEIGHT) ? S_EXP : S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= S_EXP;
                end
                S_EXP:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    xn_reg <= x;
                    e_reg  <= expo;
                    p_reg  <= P_W'(WSUM_W - 1);
                end
            end
            S_NORM:
            begin
                if (xn_reg[WSUM_W-1])
                begin
                    m_reg <= xn_reg[WSUM_W-1 -: ROOT_W];
                    f_reg <= '0;
                end
                else
                begin
                    xn_reg <= {xn_reg[WSUM_W-2:0], 1'b0};
                    p_reg  <= p_reg - P_W'(1);
                end
            end
            S_LOG:
            begin
                f_reg <= {f_reg[14:0], sq_top[31]};
                m_reg <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            end
            S_SCALE:
            begin
                neg_reg <= adiv[31];
                pw_reg  <= wsh[31:0];
                r_reg   <= ROOT_W'(1) << 30;
            end
            S_DIV:
            begin
                if (div_done)
                    pw_reg <= pq;
            end
            S_EXP:
            begin
                if (fr[4'd15 - cnt_reg])
                    r_reg <= emul[60:30];
            end
            S_FIN:
                result_reg <= v;
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/mqb_fifo.sv -----
// ----------------------------------------------------------------------------
// mqb_fifo
// Short register queue of finished pixels between front and back.
// ----------------------------------------------------------------------------
module mqb_fifo
    import mqb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mqb_entry_t din,
    output logic       full,
    input  logic       pop,
    output mqb_entry_t dout,
    output logic       empty
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    mqb_entry_t     mem_reg [QUEUE_DEPTH];
    logic [IDX_W:0] wp_reg;
    logic [IDX_W:0] rp_reg;

    assign empty = wp_reg == rp_reg;
    assign full  = (wp_reg[IDX_W] != rp_reg[IDX_W]) &&
                   (wp_reg[IDX_W-1:0] == rp_reg[IDX_W-1:0]);
    assign dout  = mem_reg[rp_reg[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= wp_reg + (IDX_W+1)'(1);
            if (pop && !empty)
                rp_reg <= rp_reg + (IDX_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg[IDX_W-1:0]] <= din;
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg - rp_reg) <= (IDX_W+1)'(QUEUE_DEPTH))
        else $error("queue fill out of range");
`endif

endmodule

// ----- rtl/mqb_front.sv -----
// ----------------------------------------------------------------------------
// mqb_front
// Takes view words, tracks the best view, weighs each view and accumulates
// primary and secondary sums; a last view hands the pixel to the queue.
// ----------------------------------------------------------------------------
module mqb_front
    import mqb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  view_t                   view,
    input  logic signed [EXP_W-1:0] expo,
    output logic                    push,
    output mqb_entry_t              entry,
    input  logic                    full
);

    typedef enum logic [4:0] {
        F_IDLE   = 5'b00001,
        F_WEIGHT = 5'b00010,
        F_MUL    = 5'b00100,
        F_ACC    = 5'b01000,
        F_PUSH   = 5'b10000
    } front_state_t;

    front_state_t               state_reg;
    front_state_t               state_next;
    logic [WSUM_W-1:0]          pws_reg;
    logic [WSUM_W-1:0]          sws_reg;
    logic [2:0][CSUM_W-1:0]     pcs_reg;
    logic [2:0][CSUM_W-1:0]     scs_reg;
    logic [QUAL_W-1:0]          bq_reg;
    logic [2:0][COLOR_BITS-1:0] bc_reg;
    logic                       bp_reg;
    logic [2:0][COLOR_BITS-1:0] col_reg;
    logic                       prol_reg;
    logic                       last_reg;
    logic [QUAL_W-1:0]          w_reg;
    logic [2:0][PROD_W-1:0]     prod_reg;

    logic              accept;
    logic              contrib;
    logic              e_zero;
    logic              e_unity;
    logic              le_start;
    logic              le_done;
    logic [QUAL_W-1:0] le_result;

    function automatic logic [WSUM_W-1:0] sat_w(input logic [WSUM_W-1:0] a,
                                                input logic [QUAL_W-1:0] b);
        logic [WSUM_W:0] s;
        s = {1'b0, a} + (WSUM_W+1)'(b);
        return s[WSUM_W] ? '1 : s[WSUM_W-1:0];
    endfunction

    function automatic logic [CSUM_W-1:0] sat_c(input logic [CSUM_W-1:0] a,
                                                input logic [PROD_W-1:0] b);
        logic [CSUM_W:0] s;
        s = {1'b0, a} + (CSUM_W+1)'(b);
        return s[CSUM_W] ? '1 : s[CSUM_W-1:0];
    endfunction

    assign in_ready = state_reg == F_IDLE;
    assign accept   = in_valid && in_ready;
    assign contrib  = !expo[EXP_W-1] && (view.quality != '0);
    assign e_zero   = expo == '0;
    assign e_unity  = expo == EXP_UNITY;
    assign le_start = accept && contrib && !e_zero && !e_unity;
    assign push     = (state_reg == F_PUSH) && !full;

    mqb_logexp u_weight (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (le_start),
        .mode   (LE_WEIGHT),
        .x      (WSUM_W'(view.quality)),
        .expo   (expo),
        .done   (le_done),
        .result (le_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (le_start)
                        state_next = F_WEIGHT;
                    else if (contrib)
                        state_next = F_MUL;
                    else if (view.last)
                        state_next = F_PUSH;
                end
            end
            F_WEIGHT:
            begin
                if (le_done)
                    state_next = F_MUL;
            end
            F_MUL:
                state_next = F_ACC;
            F_ACC:
                state_next = last_reg ? F_PUSH : F_IDLE;
            F_PUSH:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pws_reg   <= '0;
            sws_reg   <= '0;
            pcs_reg   <= '0;
            scs_reg   <= '0;
            bq_reg    <= '0;
            bc_reg    <= '0;
            bp_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (view.quality > bq_reg))
            begin
                bq_reg <= view.quality;
                bp_reg <= view.prolonged;
                bc_reg <= {view.blue, view.green, view.red};
            end
            if (state_reg == F_ACC)
            begin
                if (!prol_reg)
                begin
                    pws_reg <= sat_w(pws_reg, w_reg);
                    for (int c = 0; c < 3; c++)
                        pcs_reg[c] <= sat_c(pcs_reg[c], prod_reg[c]);
                end
                else
                begin
                    sws_reg <= sat_w(sws_reg, w_reg);
                    for (int c = 0; c < 3; c++)
                        scs_reg[c] <= sat_c(scs_reg[c], prod_reg[c]);
                end
            end
            if (push)
            begin
                pws_reg <= '0;
                sws_reg <= '0;
                pcs_reg <= '0;
                scs_reg <= '0;
                bq_reg  <= '0;
                bc_reg  <= '0;
                bp_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_reg  <= {view.blue, view.green, view.red};
            prol_reg <= view.prolonged;
            last_reg <= view.last;
            w_reg    <= e_zero ? QONE : view.quality;
        end
        if ((state_reg == F_WEIGHT) && le_done)
            w_reg <= (le_result == '0) ? QUAL_W'(1) : le_result;
        if (state_reg == F_MUL)
        begin
            for (int c = 0; c < 3; c++)
                prod_reg[c] <= w_reg * col_reg[c];
        end
    end

    always_comb
    begin
        entry.expo    = expo;
        entry.use_sec = pws_reg == '0;
        entry.wsum    = entry.use_sec ? sws_reg : pws_reg;
        entry.csum    = entry.use_sec ? scs_reg : pcs_reg;
        entry.best_q  = bq_reg;
        entry.best_c  = bc_reg;
        entry.best_p  = bp_reg;
    end

endmodule

// ----- rtl/mqb_back.sv -----
// ----------------------------------------------------------------------------
// mqb_back
// Per-pixel finish: picks the mode, divides the color sums by the weight sum
// and works out the output quality, then holds the result word.
// ----------------------------------------------------------------------------
module mqb_back
    import mqb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       empty,
    input  mqb_entry_t                 dout,
    output logic                       pop,
    input  logic [2:0][COLOR_BITS-1:0] fill_rgb,
    output logic                       out_valid,
    input  logic                       out_ready,
    output result_t                    res
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_CALC = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

    back_state_t       state_reg;
    result_t           res_reg;
    logic              div_done_reg;
    logic              q_done_reg;

    logic              avg_go;
    logic              e_zero;
    logic              e_unity;
    logic              le_start;
    logic              le_done;
    logic [QUAL_W-1:0] le_result;
    logic [2:0]        div_done;
    logic [2:0][CSUM_W-1:0] quot;
    logic [2:0][WSUM_W-1:0] rem;
    logic [2:0][COLOR_BITS-1:0] clamped;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign avg_go   = !dout.expo[EXP_W-1] && (dout.wsum != '0);
    assign e_zero   = dout.expo == '0;
    assign e_unity  = dout.expo == EXP_UNITY;
    assign le_start = pop && avg_go && !e_zero && !e_unity;

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        mqb_div #(
            .N (CSUM_W),
            .D (WSUM_W)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (pop && avg_go),
            .dividend (dout.csum[c]),
            .divisor  (dout.wsum),
            .done     (div_done[c]),
            .quot     (quot[c]),
            .rem      (rem[c])
        );
        assign clamped[c] = (quot[c][CSUM_W-1:COLOR_BITS] != '0) ? '1 :
                            quot[c][COLOR_BITS-1:0];
    end

    mqb_logexp u_quality (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (le_start),
        .mode   (LE_QUALITY),
        .x      (dout.wsum),
        .expo   (dout.expo),
        .done   (le_done),
        .result (le_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            div_done_reg <= 1'b0;
            q_done_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        div_done_reg <= 1'b0;
                        q_done_reg   <= e_zero || e_unity;
                        state_reg    <= avg_go ? B_CALC : B_OUT;
                    end
                end
                B_CALC:
                begin
                    if (div_done[0])
                        div_done_reg <= 1'b1;
                    if (le_done)
                        q_done_reg <= 1'b1;
                    if (div_done_reg && q_done_reg)
                        state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_ready)
                        state_reg <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            // no contribution unless overridden below
            {res_reg.blue, res_reg.green, res_reg.red} <= fill_rgb;
            res_reg.quality <= '0;
            res_reg.pmask   <= 1'b1;
            res_reg.inpaint <= 1'b1;
            if (dout.expo[EXP_W-1])
            begin
                if (dout.best_q != '0)
                begin
                    {res_reg.blue, res_reg.green, res_reg.red} <= dout.best_c;
                    res_reg.quality <= dout.best_q;
                    res_reg.pmask   <= dout.best_p;
                    res_reg.inpaint <= 1'b0;
                end
            end
            else if (avg_go)
            begin
                res_reg.pmask   <= dout.use_sec;
                res_reg.inpaint <= 1'b0;
                if (e_zero)
                    res_reg.quality <= (dout.wsum == WSUM_W'(QONE)) ? QONE : QMAX;
                else if (dout.wsum[WSUM_W-1:QUAL_W] != '0)
                    res_reg.quality <= QMAX;
                else
                    res_reg.quality <= dout.wsum[QUAL_W-1:0];
            end
        end
        if (state_reg == B_CALC)
        begin
            if (div_done[0])
                {res_reg.blue, res_reg.green, res_reg.red} <= clamped;
            if (le_done)
                res_reg.quality <= le_result;
        end
    end

    assign out_valid = state_reg == B_OUT;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_inpaint_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_reg.inpaint) |-> (res_reg.quality == '0 && res_reg.pmask))
        else $error("inpainted pixel with quality or without mask");
`endif

endmodule

// ----- rtl/multiview_quality_blend_core.sv -----
// ----------------------------------------------------------------------------
// multiview_quality_blend_core
// Blends one output pixel from a stream of warped views by quality weight.
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata: red, green, blue, quality
//                                     tuser: from_prolonged_depth, tlast: last
//   m_*       out  tvalid/tready      tdata: red, green, blue, quality
//                                     tuser: prolonged_mask, inpaint_flag
//   cfg_*     in   cfg_we             cfg_addr register index, cfg_wdata value
//
// A view word that adds nothing leaves the front idle; with exponent 0 or 1.0
// it passes the multiply and accumulate steps, and otherwise it first goes
// through the front's log2 normalize, 16 squarings and 16 exp2 root multiplies.
// A last view hands the pixel to a two-deep queue.
// The back runs a 56-bit color division for each averaged pixel, and also the
// power unit and its divider when the output quality needs them.
// Reset restores the default registers, clears the sums and empties the queue.
// s_tready drops while a word is in work; m_tvalid holds until m_tready.
// ----------------------------------------------------------------------------
module multiview_quality_blend_core
    import mqb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // red, green, blue, quality
    input  logic               s_tuser,  // from_prolonged_depth
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,  // red, green, blue, quality
    output logic [1:0]         m_tuser,  // prolonged_mask, inpaint_flag
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [EXP_W-1:0]   cfg_wdata
);

    logic [EXP_W-1:0]           expo_reg;
    logic [2:0][COLOR_BITS-1:0] empty_reg;

    view_t      view;
    mqb_entry_t q_din;
    mqb_entry_t q_dout;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expo_reg  <= EXP_RESET;
            empty_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_EXPONENT:    expo_reg     <= cfg_wdata;
                CFG_EMPTY_RED:   empty_reg[0] <= cfg_wdata[COLOR_BITS-1:0];
                CFG_EMPTY_GREEN: empty_reg[1] <= cfg_wdata[COLOR_BITS-1:0];
                CFG_EMPTY_BLUE:  empty_reg[2] <= cfg_wdata[COLOR_BITS-1:0];
                default:         expo_reg     <= expo_reg;
            endcase
        end
    end

    assign view.red       = s_tdata[COLOR_BITS-1:0];
    assign view.green     = s_tdata[2*COLOR_BITS-1:COLOR_BITS];
    assign view.blue      = s_tdata[3*COLOR_BITS-1:2*COLOR_BITS];
    assign view.quality   = s_tdata[3*COLOR_BITS+QUAL_W-1:3*COLOR_BITS];
    assign view.prolonged = s_tuser;
    assign view.last      = s_tlast;

    mqb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .view     (view),
        .expo     ($signed(expo_reg)),
        .push     (q_push),
        .entry    (q_din),
        .full     (q_full)
    );

    mqb_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    mqb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .dout      (q_dout),
        .pop       (q_pop),
        .fill_rgb  (empty_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = TDATA_W'({res.quality, res.blue, res.green, res.red});
    assign m_tuser = {res.inpaint, res.pmask};

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the multiview quality blend core: view words go in through a
// queue-fed driver, blended pixels are checked word by word against an
// in-bench fixed-point predictor, across several exponent and empty-color
// settings with random idling and backpressure.
// ----------------------------------------------------------------------------
module testbench;
    import mqb_pkg::*;

    typedef struct {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [QUAL_W-1:0]     quality;
        logic                  prolonged;
        logic                  last;
    } view_word_t;

    typedef struct {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [QUAL_W-1:0]     quality;
        logic                  pmask;
        logic                  inpaint;
    } pixel_t;

    localparam longint unsigned WLIM = (64'd1 << 40) - 1;
    localparam longint unsigned CLIM = (64'd1 << 56) - 1;
    localparam longint unsigned QTOP = 64'hFFFF_FFFF;
    localparam longint unsigned UNIT = 64'd1 << QFRAC_BITS;
    localparam int              SETTLE = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;     // red, green, blue, quality
    logic               s_tuser = 1'b0;   // from_prolonged_depth
    logic               s_tlast = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // red, green, blue, quality
    logic [1:0]         m_tuser;          // prolonged_mask, inpaint_flag
    logic               cfg_we = 1'b0;
    cfg_index_t         cfg_addr = CFG_EXPONENT;
    logic [EXP_W-1:0]   cfg_wdata = '0;

    multiview_quality_blend_core u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    view_word_t view_queue[$];
    pixel_t     expected_pixels[$];
    int         src_idle = 0;
    int         sink_idle = 0;
    bit         send_pause = 0;
    int         hold_req = 0;
    int         hold_ack = 0;
    int         hold_left = 0;
    int         mismatches = 0;
    int         views_in = 0;
    int         pixels_out = 0;
    int         inpaint_seen = 0;

    // mirror of configuration and per-pixel accumulators
    logic signed [EXP_W-1:0] expo_cfg = EXP_UNITY;
    longint unsigned         empty_rgb[3] = '{0, 0, 0};
    longint unsigned         prim_w, sec_w, top_q, top_p;
    longint unsigned         prim_c[3], sec_c[3], top_c[3];
    longint unsigned         roots[1:16];

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 32;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= x) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    initial
    begin
        longint unsigned c;
        c = 64'd2 << 30;
        for (int n = 1; n <= 16; n++) begin
            c = int_sqrt(c << 30);
            roots[n] = c;
        end
    end

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint log2_q16(input longint unsigned x);
        int              p;
        longint unsigned m;
        longint          f;
        p = 63;
        f = 0;
        while (p > 0 && !x[p]) p--;
        m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd2 << 30)) begin
                f = f | 1;
                m = m >> 1;
            end
        end
        return (longint'(p) - QFRAC_BITS) * 65536 + f;
    endfunction

    function automatic longint unsigned pow2_q(input longint pw);
        longint          ip, fr, sh;
        longint unsigned r, v;
        ip = floor_quot(pw, 65536);
        fr = pw - ip * 65536;
        r = 64'd1 << 30;
        for (int n = 1; n <= 16; n++)
            if (fr[16-n]) r = (r * roots[n]) >> 30;
        if (ip >= 32 - QFRAC_BITS) return QTOP;
        sh = ip + QFRAC_BITS - 30;
        if (sh >= 0) v = r << sh;
        else v = (-sh >= 63) ? 0 : (r >> (-sh));
        return (v > QTOP) ? QTOP : v;
    endfunction

    function automatic longint unsigned sat_sum(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic void clear_pixel();
        prim_w = 0; sec_w = 0; top_q = 0; top_p = 0;
        for (int c = 0; c < 3; c++) begin
            prim_c[c] = 0; sec_c[c] = 0; top_c[c] = 0;
        end
    endfunction

    // accumulates one view word; pushes a pixel when the word closes it
    function automatic void blend_view(input view_word_t v);
        longint          e;
        longint unsigned q, w, ws, rgb[3], cs[3], d;
        pixel_t          px;
        e = longint'(expo_cfg);
        q = v.quality;
        rgb[0] = v.red; rgb[1] = v.green; rgb[2] = v.blue;
        if (q > top_q) begin
            top_q = q;
            top_p = v.prolonged;
            for (int c = 0; c < 3; c++) top_c[c] = rgb[c];
        end
        if (e >= 0 && q > 0) begin
            if (e == 0) w = UNIT;
            else if (e == 256) w = q;
            else begin
                w = pow2_q(floor_quot(e * log2_q16(q), 256));
                if (w == 0) w = 1;
            end
            if (!v.prolonged) begin
                prim_w = sat_sum(prim_w, w, WLIM);
                for (int c = 0; c < 3; c++) prim_c[c] = sat_sum(prim_c[c], w * rgb[c], CLIM);
            end else begin
                sec_w = sat_sum(sec_w, w, WLIM);
                for (int c = 0; c < 3; c++) sec_c[c] = sat_sum(sec_c[c], w * rgb[c], CLIM);
            end
        end
        if (!v.last) return;
        px.red = empty_rgb[0]; px.green = empty_rgb[1]; px.blue = empty_rgb[2];
        px.quality = 0; px.pmask = 1; px.inpaint = 0;
        ws = 0;
        if (e < 0) begin
            if (top_q > 0) begin
                px.red = top_c[0]; px.green = top_c[1]; px.blue = top_c[2];
                px.quality = top_q;
                px.pmask = top_p[0];
            end else px.inpaint = 1;
        end else begin
            if (prim_w > 0) begin
                ws = prim_w; cs = prim_c; px.pmask = 0;
            end else if (sec_w > 0) begin
                ws = sec_w; cs = sec_c;
            end else px.inpaint = 1;
            if (ws > 0) begin
                for (int c = 0; c < 3; c++) begin
                    d = cs[c] / ws;
                    rgb[c] = (d > 16'hFFFF) ? 16'hFFFF : d;
                end
                px.red = rgb[0]; px.green = rgb[1]; px.blue = rgb[2];
                if (e == 0) px.quality = (ws == UNIT) ? UNIT : QTOP;
                else if (e == 256) px.quality = (ws > QTOP) ? QTOP : ws;
                else px.quality = pow2_q(floor_quot(log2_q16(ws) * 256, e));
            end
        end
        expected_pixels.push_back(px);
        clear_pixel();
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] pixel %0d: %s got %0h expected %0h", $realtime, pixels_out,
                 what, got, want);
        mismatches++;
    endtask

    // driver: keeps a word up until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) void'(view_queue.pop_front());
            if (s_tvalid && !s_tready) begin
            end else if (view_queue.size() > 0 && !send_pause &&
                         $urandom_range(99) >= src_idle) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {view_queue[0].quality, view_queue[0].blue,
                             view_queue[0].green, view_queue[0].red};
                s_tuser  <= view_queue[0].prolonged;
                s_tlast  <= view_queue[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= 3000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        view_word_t w;
        pixel_t     px;
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                w.red = s_tdata[15:0]; w.green = s_tdata[31:16]; w.blue = s_tdata[47:32];
                w.quality = s_tdata[79:48]; w.prolonged = s_tuser; w.last = s_tlast;
                blend_view(w);
                views_in++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("unexpected pixel, quality", m_tdata[79:48], 0);
                end else begin
                    px = expected_pixels.pop_front();
                    if (m_tdata[15:0] !== px.red) report_mismatch("red", m_tdata[15:0], px.red);
                    if (m_tdata[31:16] !== px.green)
                        report_mismatch("green", m_tdata[31:16], px.green);
                    if (m_tdata[47:32] !== px.blue)
                        report_mismatch("blue", m_tdata[47:32], px.blue);
                    if (m_tdata[79:48] !== px.quality)
                        report_mismatch("quality", m_tdata[79:48], px.quality);
                    if (m_tuser[0] !== px.pmask) report_mismatch("pmask", m_tuser[0], px.pmask);
                    if (m_tuser[1] !== px.inpaint)
                        report_mismatch("inpaint", m_tuser[1], px.inpaint);
                    if (px.inpaint) inpaint_seen++;
                end
                pixels_out++;
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [EXP_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EXPONENT) expo_cfg = val;
        else empty_rgb[int'(idx) - 1] = val;
    endtask

    task automatic drain();
        while (view_queue.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_view(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                            input logic [31:0] q, input bit prol, input bit last);
        view_word_t w;
        w.red = r; w.green = g; w.blue = b; w.quality = q; w.prolonged = prol; w.last = last;
        view_queue.push_back(w);
    endtask

    function automatic logic [31:0] rand_quality();
        case ($urandom_range(9))
            0, 1:    return 0;
            2:       return $urandom_range(255);
            3:       return 32'hFFFF_FFFF;
            4, 5:    return $urandom_range(32'h0003_0000, 32'h0000_4000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_color();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_pixel();
        int n, mode;
        bit prol;
        n = ($urandom_range(9) == 0) ? $urandom_range(20) + 1 : $urandom_range(4) + 1;
        mode = $urandom_range(3);  // 0 all primary, 1 all prolonged, else mixed
        for (int i = 0; i < n; i++) begin
            prol = (mode == 0) ? 0 : (mode == 1) ? 1 : $urandom_range(1);
            add_view(rand_color(), rand_color(), rand_color(), rand_quality(), prol, i == n - 1);
        end
    endtask

    task automatic random_words(input int count);
        int start;
        start = view_queue.size();
        while (view_queue.size() - start < count) add_pixel();
        // only whole pixels are added, each closed by a last word, so count may be overshot
    endtask

    initial
    begin
        logic [15:0] expo_set[10];
        clear_pixel();
        expo_set = '{16'd0, 16'hFFFF, 16'h7FFF, 16'h8000, 16'd128, 16'd384, 16'd1,
                     16'd512, 16'hFF00, 16'd256};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, unity exponent
        @(negedge clk);
        add_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1);
        add_view(16'h0000, 16'h0000, 16'h0000, 32'h0000_0001, 0, 1);
        add_view(16'h1234, 16'h5678, 16'h9ABC, 32'h0, 0, 0);
        add_view(16'h1111, 16'h2222, 16'h3333, 32'h0, 1, 1);          // nothing counts
        add_view(16'hAAAA, 16'h5555, 16'h0F0F, 32'h0001_0000, 1, 0);  // prolonged only
        add_view(16'h5555, 16'hAAAA, 16'hF0F0, 32'h0002_0000, 1, 1);
        add_view(16'h0100, 16'h0200, 16'h0300, 32'h0001_0000, 1, 0);
        add_view(16'h0400, 16'h0500, 16'h0600, 32'h0001_0000, 0, 1);  // primary wins
        for (int i = 0; i < 18; i++)                                  // overlong
            add_view(16'hFFFF, 16'h8000, 16'h0001, 32'hFFFF_FFFF, 0, i == 17);
        drain();
        write_reg(CFG_EMPTY_RED, 16'hFFFF);
        write_reg(CFG_EMPTY_GREEN, 16'h8001);
        write_reg(CFG_EMPTY_BLUE, 16'h7FFE);
        write_reg(CFG_EXPONENT, 16'hFF00);
        @(negedge clk);
        add_view(16'h0001, 16'h0002, 16'h0003, 32'h0005_0000, 1, 0);  // ties in max mode
        add_view(16'h0004, 16'h0005, 16'h0006, 32'h0005_0000, 0, 1);
        add_view(16'h0004, 16'h0005, 16'h0006, 32'h0, 0, 1);
        drain();
        // exponent changed inside a pixel
        write_reg(CFG_EXPONENT, 16'd256);
        @(negedge clk);
        add_view(16'h7777, 16'h8888, 16'h9999, 32'h0000_8000, 0, 0);
        drain();
        write_reg(CFG_EXPONENT, 16'h8000);
        @(negedge clk);
        add_view(16'h1010, 16'h2020, 16'h3030, 32'h0001_0000, 1, 0);
        drain();
        write_reg(CFG_EXPONENT, 16'd0);
        @(negedge clk);
        add_view(16'h4040, 16'h5050, 16'h6060, 32'h0000_4000, 0, 1);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_EXPONENT, expo_set[ph]);
            write_reg(CFG_EMPTY_RED, (ph % 3 == 0) ? 16'h0 : 16'($urandom));
            write_reg(CFG_EMPTY_GREEN, (ph % 3 == 1) ? 16'hFFFF : 16'($urandom));
            write_reg(CFG_EMPTY_BLUE, 16'($urandom));
            @(negedge clk);
            if (ph < 4) begin
                src_idle = 31; sink_idle = 76;
            end else if (ph < 7) begin
                src_idle = 76; sink_idle = 31;
            end else begin
                src_idle = 0; sink_idle = 0;
            end
            random_words(110);
            if (ph == 8) begin
                hold_req++;                      // receiver stalls, sender keeps going
                repeat (50) @(negedge clk);
            end
            if (ph == 5) begin
                while (view_queue.size() > 60) @(negedge clk);
                send_pause = 1;
                while (expected_pixels.size() > 0) @(negedge clk);
                repeat ($urandom_range(20)) @(negedge clk);
                send_pause = 0;
            end
            drain();
        end

        $display("Fed %0d view words; %0d pixels blended, %0d needing inpaint,",
                 views_in, pixels_out, inpaint_seen);
        $display("over 10 exponent values incl. max mode, zero and unity exponent.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule
